// ===== hw/rtl/nrspm_pkg.sv =====
// Shared types, constants and the helper function of the NAND RAID stripe page mapper.
package nrspm_pkg;

   localparam int MAX_PAGES_PER_BLOCK = 4096;
   localparam int MAX_BLOCKS          = 65536;

   localparam int PAGE_BYTES_W = 17;
   localparam int OOB_BYTES_W  = 13;
   localparam int PPB_W        = 13;
   localparam int BLOCKS_W     = 17;
   localparam int DPAGES_W     = 4;

   localparam int LP_W      = 28;
   localparam int BLK_W     = 16;
   localparam int STR_W     = 12;
   localparam int PAGE_W    = 28;
   localparam int SPB_W     = 13;
   localparam int TAIL_W    = 4;
   localparam int LPB_W     = 20;
   localparam int LOOB_W    = 16;
   localparam int CAP_W     = 45;
   localparam int TOTAL_W   = SPB_W + BLOCKS_W;
   localparam int SLEN_W    = DPAGES_W + 1;
   localparam int SHIFT_W   = 2;
   localparam int REM_W     = SPB_W;
   localparam int RECIP_W   = 15;
   localparam int RECIP_SH  = 16;
   localparam int BASE_W    = BLK_W + PPB_W;
   localparam int STROFF_W  = STR_W + SLEN_W + 1;
   localparam int CAPPROD_W = PAGE_BYTES_W + TOTAL_W;

   localparam int DIV_STAGES = BLK_W;

   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 184;
   localparam int RSP_PAD_W   = RSP_DATA_W - (BLK_W + STR_W + 2 * PAGE_W + SPB_W + TAIL_W
                                              + LPB_W + LOOB_W + CAP_W);
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 17;

   localparam logic [PAGE_BYTES_W-1:0] RESET_PAGE_BYTES = 17'd16384;
   localparam logic [OOB_BYTES_W-1:0]  RESET_OOB_BYTES  = 13'd1024;
   localparam logic [PPB_W-1:0]        RESET_PPB        = 13'd256;
   localparam logic [BLOCKS_W-1:0]     RESET_BLOCKS     = 17'd1024;
   localparam logic                    RESET_RAID       = 1'b0;
   localparam logic [DPAGES_W-1:0]     RESET_DPAGES     = 4'd4;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_CFG = 2'd1,
      STATUS_RANGE   = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_PAGE_BYTES     = 3'd0,
      REG_OOB_BYTES      = 3'd1,
      REG_PAGES_PER_BLK  = 3'd2,
      REG_BLOCK_COUNT    = 3'd3,
      REG_RAID_MODE      = 3'd4,
      REG_DATA_PAGES     = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic                ok;
      logic                raid;
      logic [DPAGES_W-1:0] dp;
      logic [SLEN_W-1:0]   slen;
      logic [PPB_W-1:0]    ppb;
      logic [SPB_W-1:0]    spb;
      logic [TAIL_W-1:0]   tail;
      logic [TOTAL_W-1:0]  total;
      logic [LPB_W-1:0]    lpb;
      logic [LOOB_W-1:0]   loob;
      logic [CAP_W-1:0]    cap;
   } geom_type;

   typedef struct packed {
      status_type       status;
      logic [LP_W-1:0]  lp;
   } queue_entry_type;

   typedef struct packed {
      status_type        status;
      logic [REM_W-1:0]  rem;
      logic [BLK_W-1:0]  quo;
      logic [BLK_W-1:0]  low;
   } div_type;

   function automatic div_type div_step(input div_type cur, input logic [SPB_W-1:0] divisor);
      div_type          nxt;
      logic [REM_W:0]   trial;
      trial    = {cur.rem, cur.low[BLK_W-1]};
      nxt      = cur;
      nxt.low  = {cur.low[BLK_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
         nxt.rem = REM_W'(trial - {1'b0, divisor});
         nxt.quo = {cur.quo[BLK_W-2:0], 1'b1};
      end else begin
         nxt.rem = trial[REM_W-1:0];
         nxt.quo = {cur.quo[BLK_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

endpackage

// ===== hw/rtl/nrspm_geom.sv =====
// Configuration registers and the pipelined derivation of the stripe geometry.
module nrspm_geom (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [nrspm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [nrspm_pkg::CSR_DATA_W-1:0]   csr_data,
   output nrspm_pkg::geom_type                geom
);
   import nrspm_pkg::*;

   logic [PAGE_BYTES_W-1:0] page_bytes_ff;
   logic [OOB_BYTES_W-1:0]  oob_bytes_ff;
   logic [PPB_W-1:0]        ppb_ff;
   logic [BLOCKS_W-1:0]     blocks_ff;
   logic                    raid_ff;
   logic [DPAGES_W-1:0]     dpages_ff;

   logic                    ok1_in, ok1_ff;
   logic [DPAGES_W-1:0]     dp1_in, dp1_ff;
   logic [SLEN_W-1:0]       slen1_in, slen1_ff;
   logic [SHIFT_W-1:0]      shift1_in, shift1_ff;
   logic [SPB_W-1:0]        spb1_in, spb1_ff;
   logic                    raid1_ff;
   logic                    dp_legal;
   logic [RECIP_W-1:0]      recip;
   logic [PPB_W+RECIP_W:0]  quot_prod;

   logic                    ok2_in, ok2_ff;
   logic [SPB_W-1:0]        spb2_ff;
   logic [PPB_W-1:0]        covered_pages;
   logic [PPB_W-1:0]        tail_full;
   logic [TAIL_W-1:0]       tail2_in, tail2_ff;
   logic [TOTAL_W-1:0]      total2_in, total2_ff;
   logic [LPB_W-1:0]        lpb2_in, lpb2_ff;
   logic [LOOB_W-1:0]       loob2_in, loob2_ff;
   logic [SHIFT_W-1:0]      shift2_ff;

   logic [CAPPROD_W-1:0]    cap_prod;
   logic [CAP_W-1:0]        cap3_in, cap3_ff;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_bytes_ff <= RESET_PAGE_BYTES;
         oob_bytes_ff  <= RESET_OOB_BYTES;
         ppb_ff        <= RESET_PPB;
         blocks_ff     <= RESET_BLOCKS;
         raid_ff       <= RESET_RAID;
         dpages_ff     <= RESET_DPAGES;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_PAGE_BYTES:    page_bytes_ff <= csr_data[PAGE_BYTES_W-1:0];
            REG_OOB_BYTES:     oob_bytes_ff  <= csr_data[OOB_BYTES_W-1:0];
            REG_PAGES_PER_BLK: ppb_ff        <= csr_data[PPB_W-1:0];
            REG_BLOCK_COUNT:   blocks_ff     <= csr_data[BLOCKS_W-1:0];
            REG_RAID_MODE:     raid_ff       <= csr_data[0];
            REG_DATA_PAGES:    dpages_ff     <= csr_data[DPAGES_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      dp_legal = (dpages_ff == 4'd2) || (dpages_ff == 4'd4) || (dpages_ff == 4'd8);
      ok1_in   = (page_bytes_ff != '0) && (oob_bytes_ff != '0) && (ppb_ff != '0) &&
                 (blocks_ff != '0) && (ppb_ff <= PPB_W'(MAX_PAGES_PER_BLOCK)) &&
                 (blocks_ff <= BLOCKS_W'(MAX_BLOCKS)) && (!raid_ff || dp_legal);
      dp1_in   = raid_ff ? dpages_ff : DPAGES_W'(1);
      slen1_in = raid_ff ? (SLEN_W'(dpages_ff) + SLEN_W'(1)) : SLEN_W'(1);
      case (dpages_ff)
         4'd2:    shift1_in = raid_ff ? 2'd1 : 2'd0;
         4'd4:    shift1_in = raid_ff ? 2'd2 : 2'd0;
         4'd8:    shift1_in = raid_ff ? 2'd3 : 2'd0;
         default: shift1_in = 2'd0;
      endcase
      case (slen1_in)
         5'd3:    recip = 15'd21846;
         5'd5:    recip = 15'd13108;
         5'd9:    recip = 15'd7282;
         default: recip = '0;
      endcase
      quot_prod = (PPB_W+RECIP_W+1)'(ppb_ff) * (PPB_W+RECIP_W+1)'(recip);
      spb1_in   = (slen1_in == SLEN_W'(1)) ? ppb_ff : quot_prod[RECIP_SH +: SPB_W];
   end

   always_ff @(posedge clock) begin
      ok1_ff    <= ok1_in;
      raid1_ff  <= raid_ff;
      dp1_ff    <= dp1_in;
      slen1_ff  <= slen1_in;
      shift1_ff <= shift1_in;
      spb1_ff   <= spb1_in;
   end

   always_comb begin
      ok2_in        = ok1_ff && (spb1_ff != '0);
      covered_pages = PPB_W'(spb1_ff * PPB_W'(slen1_ff));
      tail_full     = ppb_ff - covered_pages;
      tail2_in      = tail_full[TAIL_W-1:0];
      total2_in     = TOTAL_W'(spb1_ff) * TOTAL_W'(blocks_ff);
      lpb2_in       = LPB_W'(page_bytes_ff) << shift1_ff;
      loob2_in      = LOOB_W'(oob_bytes_ff) << shift1_ff;
   end

   always_ff @(posedge clock) begin
      ok2_ff    <= ok2_in;
      spb2_ff   <= spb1_ff;
      tail2_ff  <= tail2_in;
      total2_ff <= total2_in;
      lpb2_ff   <= lpb2_in;
      loob2_ff  <= loob2_in;
      shift2_ff <= shift1_ff;
   end

   always_comb begin
      cap_prod = CAPPROD_W'(page_bytes_ff) * CAPPROD_W'(total2_ff);
      cap3_in  = CAP_W'(cap_prod << shift2_ff);
   end

   always_ff @(posedge clock) begin
      cap3_ff <= cap3_in;
   end

   always_comb begin
      geom.ok    = ok2_ff;
      geom.raid  = raid1_ff;
      geom.dp    = dp1_ff;
      geom.slen  = slen1_ff;
      geom.ppb   = ppb_ff;
      geom.spb   = spb2_ff;
      geom.tail  = tail2_ff;
      geom.total = total2_ff;
      geom.lpb   = lpb2_ff;
      geom.loob  = loob2_ff;
      geom.cap   = cap3_ff;
   end

endmodule

// ===== hw/rtl/nrspm_front.sv =====
// Front end: accepts requests and classifies them as valid, bad configuration or out of range.
module nrspm_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [nrspm_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  nrspm_pkg::geom_type               geom,
   input  logic [nrspm_pkg::QCNT_W-1:0]      queue_count,
   output logic                              push,
   output nrspm_pkg::queue_entry_type        push_entry
);
   import nrspm_pkg::*;

   logic             v1_ff, v2_ff;
   logic [LP_W-1:0]  lp1_ff, lp2_ff;
   logic             accept;

   assign req_tready = !reset &&
                       ((queue_count + QCNT_W'(v1_ff) + QCNT_W'(v2_ff)) < QCNT_W'(QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      lp1_ff <= req_tdata[LP_W-1:0];
      lp2_ff <= lp1_ff;
   end

   always_comb begin
      push          = v2_ff;
      push_entry.lp = lp2_ff;
      if (!geom.ok) begin
         push_entry.status = STATUS_BAD_CFG;
      end else if (TOTAL_W'(lp2_ff) >= geom.total) begin
         push_entry.status = STATUS_RANGE;
      end else begin
         push_entry.status = STATUS_OK;
      end
   end

endmodule

// ===== hw/rtl/nrspm_queue.sv =====
// Short first-in first-out queue of classified requests between the front and back ends.
module nrspm_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  nrspm_pkg::queue_entry_type    push_entry,
   input  logic                          pop,
   output logic                          not_empty,
   output nrspm_pkg::queue_entry_type    head,
   output logic [nrspm_pkg::QCNT_W-1:0]  count
);
   import nrspm_pkg::*;

   queue_entry_type     entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_pop;

   assign not_empty = (count_ff != '0);
   assign do_pop    = pop && not_empty;
   assign head      = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

   always_comb begin
      wr_ptr_in = push   ? (wr_ptr_ff + QPTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = do_pop ? (rd_ptr_ff + QPTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff + QCNT_W'(push) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hw/rtl/nrspm_back.sv =====
// Back end: pipelined divider, physical page arithmetic and the response register.
module nrspm_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              not_empty,
   input  nrspm_pkg::queue_entry_type        head,
   output logic                              pop,
   input  nrspm_pkg::geom_type               geom,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [nrspm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [1:0]                        rsp_tuser
);
   import nrspm_pkg::*;

   div_type              div_in  [DIV_STAGES+1];
   div_type              div_ff  [DIV_STAGES+1];
   logic                 dv_ff   [DIV_STAGES+1];

   logic                 advance;

   logic [STR_W-1:0]     stripe;
   logic [BASE_W-1:0]    base_in, base_ff;
   logic [STROFF_W-1:0]  str_first_in, str_first_ff;
   logic [STROFF_W-1:0]  str_par_in, str_par_ff;
   logic                 p1_valid_ff;
   status_type           p1_status_ff;
   logic [BLK_W-1:0]     p1_blk_ff;
   logic [STR_W-1:0]     p1_stripe_ff;

   logic                 out_valid_ff;
   status_type           out_status_ff;
   logic                 p1_ok;
   logic [BLK_W-1:0]     out_blk_in, out_blk_ff;
   logic [STR_W-1:0]     out_stripe_in, out_stripe_ff;
   logic [PAGE_W-1:0]    out_first_in, out_first_ff;
   logic [PAGE_W-1:0]    out_parity_in, out_parity_ff;
   logic                 out_ok;

   assign advance = !out_valid_ff || rsp_tready;
   assign pop     = advance && not_empty;

   always_comb begin
      div_in[0].status = head.status;
      div_in[0].rem    = REM_W'(head.lp[LP_W-1:BLK_W]);
      div_in[0].quo    = '0;
      div_in[0].low    = head.lp[BLK_W-1:0];
      for (int k = 0; k < DIV_STAGES; k++) begin
         div_in[k+1] = div_step(div_ff[k], geom.spb);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= DIV_STAGES; k++) begin
            dv_ff[k] <= 1'b0;
         end
         p1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         dv_ff[0] <= not_empty;
         for (int k = 0; k < DIV_STAGES; k++) begin
            dv_ff[k+1] <= dv_ff[k];
         end
         p1_valid_ff  <= dv_ff[DIV_STAGES];
         out_valid_ff <= p1_valid_ff;
      end
   end

   always_comb begin
      stripe       = div_ff[DIV_STAGES].rem[STR_W-1:0];
      base_in      = BASE_W'(div_ff[DIV_STAGES].quo) * BASE_W'(geom.ppb);
      str_first_in = STROFF_W'(stripe) * STROFF_W'(geom.slen);
      str_par_in   = str_first_in + (geom.raid ? STROFF_W'(geom.dp) : '0);
   end

   always_comb begin
      p1_ok         = (p1_status_ff == STATUS_OK);
      out_blk_in    = p1_ok ? p1_blk_ff : '0;
      out_stripe_in = p1_ok ? p1_stripe_ff : '0;
      out_first_in  = p1_ok ? PAGE_W'(base_ff + BASE_W'(str_first_ff)) : '0;
      out_parity_in = p1_ok ? PAGE_W'(base_ff + BASE_W'(str_par_ff)) : '0;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k <= DIV_STAGES; k++) begin
            div_ff[k] <= div_in[k];
         end
         base_ff       <= base_in;
         str_first_ff  <= str_first_in;
         str_par_ff    <= str_par_in;
         p1_status_ff  <= div_ff[DIV_STAGES].status;
         p1_blk_ff     <= div_ff[DIV_STAGES].quo;
         p1_stripe_ff  <= stripe;
         out_status_ff <= p1_status_ff;
         out_blk_ff    <= out_blk_in;
         out_stripe_ff <= out_stripe_in;
         out_first_ff  <= out_first_in;
         out_parity_ff <= out_parity_in;
      end
   end

   assign out_ok     = (out_status_ff == STATUS_OK);
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_status_ff;
   assign rsp_tdata  = {RSP_PAD_W'(0),
                        out_ok ? geom.cap  : CAP_W'(0),
                        out_ok ? geom.loob : LOOB_W'(0),
                        out_ok ? geom.lpb  : LPB_W'(0),
                        out_ok ? geom.tail : TAIL_W'(0),
                        out_ok ? geom.spb  : SPB_W'(0),
                        out_parity_ff,
                        out_first_ff,
                        out_stripe_ff,
                        out_blk_ff};

endmodule

// ===== hw/rtl/nand_raid_stripe_page_mapper.sv =====
// Top level of the NAND RAID stripe page mapper.
//
//  Channel  Direction  Handshake             Contents
//  req_     in         req_tvalid/tready     logical page number
//  rsp_     out        rsp_tvalid/tready     status, page position and logical geometry
//  csr_     in         csr_valid/ready       register index and write data
//
// One request is accepted per cycle while the queue has room; the divider in the back end
// has one stage per quotient bit. Reset restores the default geometry, and the derived
// geometry follows a write to the configuration registers.
// A stalled response holds the back end while the front end keeps filling its queue.
module nand_raid_stripe_page_mapper (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [27:0] page number, [31:28] zero
   input  logic [nrspm_pkg::REQ_DATA_W-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [15:0] block, [27:16] stripe, [55:28] first page,
   // [83:56] parity, [96:84] stripe count, [100:97] unused pages,
   // [120:101] page size, [136:121] oob size,
   // [181:137] capacity, [183:182] zero
   output logic [nrspm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // [1:0] status
   output logic [1:0]                        rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [nrspm_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [nrspm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import nrspm_pkg::*;

   geom_type            geom;
   logic                push;
   queue_entry_type     push_entry;
   logic                pop;
   logic                not_empty;
   queue_entry_type     head;
   logic [QCNT_W-1:0]   queue_count;

   nrspm_geom u_geom (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .geom      (geom)
   );

   nrspm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .geom        (geom),
      .queue_count (queue_count),
      .push        (push),
      .push_entry  (push_entry)
   );

   nrspm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .not_empty  (not_empty),
      .head       (head),
      .count      (queue_count)
   );

   nrspm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .not_empty  (not_empty),
      .head       (head),
      .pop        (pop),
      .geom       (geom),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the NAND RAID stripe page mapper: directed table, random geometry.
`timescale 1ns / 1ps

module tb;
   import nrspm_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 3'd7;
   localparam int RANDOM_PHASES    = 16;
   localparam int PAGES_PER_PHASE  = 95;
   localparam int SETTLE_CYCLES    = 8;
   localparam int HOLD_OFF_CYCLES  = 300;
   localparam int HOLD_OFF_PHASE   = 7;
   localparam int TAIL_CYCLES      = 40;

   typedef struct packed {
      logic [RSP_PAD_W-1:0] pad;
      logic [CAP_W-1:0]     cap;
      logic [LOOB_W-1:0]    loob;
      logic [LPB_W-1:0]     lpb;
      logic [TAIL_W-1:0]    tail;
      logic [SPB_W-1:0]     spb;
      logic [PAGE_W-1:0]    parity;
      logic [PAGE_W-1:0]    first;
      logic [STR_W-1:0]     stripe;
      logic [BLK_W-1:0]     blk;
   } page_map_type;

   typedef struct packed {
      status_type   status;
      page_map_type map;
   } mapping_type;

   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_PAGE,
      ROW_TYPED
   } row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      logic [CSR_INDEX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0]   data;
      logic [LP_W-1:0]         lp;
      mapping_type             want;
   } directed_row_type;

   localparam mapping_type MAP_RANGE   = '{status: STATUS_RANGE, map: '0};
   localparam mapping_type MAP_BAD_CFG = '{status: STATUS_BAD_CFG, map: '0};
   localparam mapping_type MAP_RESET_FIRST = '{status: STATUS_OK, map: '{
      pad: '0, cap: 45'd4294967296, loob: 16'd1024, lpb: 20'd16384, tail: '0,
      spb: 13'd256, parity: '0, first: '0, stripe: '0, blk: '0}};
   localparam mapping_type MAP_RESET_LAST = '{status: STATUS_OK, map: '{
      pad: '0, cap: 45'd4294967296, loob: 16'd1024, lpb: 20'd16384, tail: '0,
      spb: 13'd256, parity: 28'd262143, first: 28'd262143, stripe: 12'd255,
      blk: 16'd1023}};

   localparam int DIRECTED_ROWS = 51;
   localparam directed_row_type DIRECTED_TABLE [DIRECTED_ROWS] = '{
      '{ROW_TYPED, '0, '0, 28'd0, MAP_RESET_FIRST},
      '{ROW_TYPED, '0, '0, 28'd262143, MAP_RESET_LAST},
      '{ROW_TYPED, '0, '0, 28'd262144, MAP_RANGE},
      '{ROW_TYPED, '0, '0, 28'hFFFFFFF, MAP_RANGE},
      '{ROW_WRITE, REG_RAID_MODE, 17'd1, '0, '0},
      '{ROW_PAGE, '0, '0, 28'd0, '0},
      '{ROW_PAGE, '0, '0, 28'd52223, '0},
      '{ROW_PAGE, '0, '0, 28'd52224, '0},
      '{ROW_WRITE, REG_DATA_PAGES, 17'd3, '0, '0},
      '{ROW_TYPED, '0, '0, 28'd0, MAP_BAD_CFG},
      '{ROW_WRITE, REG_DATA_PAGES, 17'd8, '0, '0},
      '{ROW_PAGE, '0, '0, 28'd12345, '0},
      '{ROW_WRITE, REG_DATA_PAGES, 17'd2, '0, '0},
      '{ROW_PAGE, '0, '0, 28'd87039, '0},
      '{ROW_WRITE, REG_PAGES_PER_BLK, 17'd2, '0, '0},
      '{ROW_TYPED, '0, '0, 28'd0, MAP_BAD_CFG},
      '{ROW_WRITE, REG_PAGES_PER_BLK, 17'd4096, '0, '0},
      '{ROW_WRITE, REG_BLOCK_COUNT, 17'd65536, '0, '0},
      '{ROW_WRITE, REG_PAGE_BYTES, 17'd65536, '0, '0},
      '{ROW_WRITE, REG_OOB_BYTES, 17'd4096, '0, '0},
      '{ROW_WRITE, REG_RAID_MODE, 17'd0, '0, '0},
      '{ROW_PAGE, '0, '0, 28'hFFFFFFF, '0},
      '{ROW_PAGE, '0, '0, 28'd0, '0},
      '{ROW_WRITE, REG_RAID_MODE, 17'd1, '0, '0},
      '{ROW_WRITE, REG_DATA_PAGES, 17'd8, '0, '0},
      '{ROW_PAGE, '0, '0, 28'h1234567, '0},
      '{ROW_WRITE, REG_PAGES_PER_BLK, 17'd4097, '0, '0},
      '{ROW_TYPED, '0, '0, 28'd5, MAP_BAD_CFG},
      '{ROW_WRITE, REG_PAGES_PER_BLK, 17'd8191, '0, '0},
      '{ROW_TYPED, '0, '0, 28'd5, MAP_BAD_CFG},
      '{ROW_WRITE, REG_PAGES_PER_BLK, 17'd9, '0, '0},
      '{ROW_WRITE, REG_BLOCK_COUNT, 17'd65537, '0, '0},
      '{ROW_TYPED, '0, '0, 28'd0, MAP_BAD_CFG},
      '{ROW_WRITE, REG_BLOCK_COUNT, 17'd0, '0, '0},
      '{ROW_TYPED, '0, '0, 28'd0, MAP_BAD_CFG},
      '{ROW_WRITE, REG_BLOCK_COUNT, 17'd1, '0, '0},
      '{ROW_WRITE, REG_PAGE_BYTES, 17'd0, '0, '0},
      '{ROW_TYPED, '0, '0, 28'd0, MAP_BAD_CFG},
      '{ROW_WRITE, REG_PAGE_BYTES, 17'd131071, '0, '0},
      '{ROW_WRITE, REG_OOB_BYTES, 17'd0, '0, '0},
      '{ROW_TYPED, '0, '0, 28'd0, MAP_BAD_CFG},
      '{ROW_WRITE, REG_OOB_BYTES, 17'd8191, '0, '0},
      '{ROW_WRITE, REG_RAID_MODE, 17'd0, '0, '0},
      '{ROW_WRITE, REG_DATA_PAGES, 17'd15, '0, '0},
      '{ROW_WRITE, REG_UNUSED, 17'h1FFFF, '0, '0},
      '{ROW_PAGE, '0, '0, 28'd3, '0},
      '{ROW_PAGE, '0, '0, 28'd8, '0},
      '{ROW_TYPED, '0, '0, 28'd9, MAP_RANGE},
      '{ROW_WRITE, REG_PAGES_PER_BLK, 17'd1, '0, '0},
      '{ROW_PAGE, '0, '0, 28'd0, '0},
      '{ROW_TYPED, '0, '0, 28'd1, MAP_RANGE}
   };

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [1:0]              rsp_tuser;
   logic                    csr_valid;
   logic                    csr_ready;
   logic [CSR_INDEX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0]   csr_data;

   logic [PAGE_BYTES_W-1:0] cfg_page_bytes;
   logic [OOB_BYTES_W-1:0]  cfg_oob_bytes;
   logic [PPB_W-1:0]        cfg_ppb;
   logic [BLOCKS_W-1:0]     cfg_blocks;
   logic                    cfg_raid;
   logic [DPAGES_W-1:0]     cfg_data_pages;

   mapping_type expected_maps [$];
   int          mismatch_count = 0;
   bit          steady         = 1'b0;
   bit          hold_request   = 1'b0;

   nand_raid_stripe_page_mapper dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   function automatic void apply_register(input logic [CSR_INDEX_W-1:0] idx,
                                          input logic [CSR_DATA_W-1:0] data);
      case (idx)
         REG_PAGE_BYTES:    cfg_page_bytes = data[PAGE_BYTES_W-1:0];
         REG_OOB_BYTES:     cfg_oob_bytes  = data[OOB_BYTES_W-1:0];
         REG_PAGES_PER_BLK: cfg_ppb        = data[PPB_W-1:0];
         REG_BLOCK_COUNT:   cfg_blocks     = data[BLOCKS_W-1:0];
         REG_RAID_MODE:     cfg_raid       = data[0];
         REG_DATA_PAGES:    cfg_data_pages = data[DPAGES_W-1:0];
         default: ;
      endcase
   endfunction

   function automatic mapping_type map_page(input logic [LP_W-1:0] lp);
      mapping_type res;
      logic [63:0] dp;
      logic [63:0] slen;
      logic [63:0] spb;
      logic [63:0] total;
      logic [63:0] blk;
      logic [63:0] stripe;
      logic [63:0] first;
      bit          usable;
      res    = '{status: STATUS_OK, map: '0};
      usable = cfg_page_bytes != 0 && cfg_oob_bytes != 0 && cfg_ppb != 0 && cfg_blocks != 0
               && cfg_ppb <= MAX_PAGES_PER_BLOCK && cfg_blocks <= MAX_BLOCKS;
      dp     = cfg_raid ? 64'(cfg_data_pages) : 64'd1;
      slen   = cfg_raid ? dp + 64'd1 : 64'd1;
      if (cfg_raid && !(dp == 64'd2 || dp == 64'd4 || dp == 64'd8)) begin
         usable = 1'b0;
      end
      spb   = usable ? 64'(cfg_ppb) / slen : 64'd0;
      total = spb * 64'(cfg_blocks);
      if (spb == 64'd0) begin
         res.status = STATUS_BAD_CFG;
      end else if (64'(lp) >= total) begin
         res.status = STATUS_RANGE;
      end else begin
         blk            = 64'(lp) / spb;
         stripe         = 64'(lp) % spb;
         first          = blk * 64'(cfg_ppb) + stripe * slen;
         res.map.blk    = BLK_W'(blk);
         res.map.stripe = STR_W'(stripe);
         res.map.first  = PAGE_W'(first);
         res.map.parity = PAGE_W'(cfg_raid ? first + dp : first);
         res.map.spb    = SPB_W'(spb);
         res.map.tail   = TAIL_W'(64'(cfg_ppb) - spb * slen);
         res.map.lpb    = LPB_W'(64'(cfg_page_bytes) * dp);
         res.map.loob   = LOOB_W'(64'(cfg_oob_bytes) * dp);
         res.map.cap    = CAP_W'(64'(cfg_page_bytes) * dp * spb * 64'(cfg_blocks));
      end
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   task automatic send_page(input logic [LP_W-1:0] lp, input mapping_type want);
      req_tdata  = REQ_DATA_W'(lp);
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_maps.push_back(want);
      @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_index = idx;
      csr_data  = data;
      csr_valid = 1'b1;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, data);
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_tvalid = 1'b0;
      while (expected_maps.size() != 0) @(negedge clock);
   endtask

   task automatic let_geometry_settle();
      csr_valid = 1'b0;
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin : stimulus
      directed_row_type        row;
      mapping_type             probe;
      logic [63:0]             total;
      logic [LP_W-1:0]         lp;
      logic [CSR_DATA_W-1:0]   geometry [6];
      int                      pick;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      cfg_page_bytes = RESET_PAGE_BYTES;
      cfg_oob_bytes  = RESET_OOB_BYTES;
      cfg_ppb        = RESET_PPB;
      cfg_blocks     = RESET_BLOCKS;
      cfg_raid       = RESET_RAID;
      cfg_data_pages = RESET_DPAGES;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      let_geometry_settle();

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         row = DIRECTED_TABLE[i];
         if (row.kind == ROW_WRITE) begin
            if (i == 0 || DIRECTED_TABLE[i-1].kind != ROW_WRITE) begin
               wait_for_results();
            end
            write_register(row.idx, row.data);
            if (i == DIRECTED_ROWS - 1 || DIRECTED_TABLE[i+1].kind != ROW_WRITE) begin
               let_geometry_settle();
            end
         end else begin
            send_page(row.lp, row.kind == ROW_TYPED ? row.want : map_page(row.lp));
         end
      end

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_results();
         case ($urandom_range(0, 19))
            0:       geometry[REG_PAGE_BYTES] = '0;
            1:       geometry[REG_PAGE_BYTES] = CSR_DATA_W'($urandom_range(65537, 131071));
            default: geometry[REG_PAGE_BYTES] = CSR_DATA_W'($urandom_range(1, 65536));
         endcase
         case ($urandom_range(0, 19))
            0:       geometry[REG_OOB_BYTES] = '0;
            1:       geometry[REG_OOB_BYTES] = CSR_DATA_W'($urandom_range(4097, 131071));
            default: geometry[REG_OOB_BYTES] = CSR_DATA_W'($urandom_range(1, 4096));
         endcase
         case ($urandom_range(0, 19))
            0:       geometry[REG_PAGES_PER_BLK] = '0;
            1:       geometry[REG_PAGES_PER_BLK] = CSR_DATA_W'($urandom_range(4097, 131071));
            2, 3:    geometry[REG_PAGES_PER_BLK] = CSR_DATA_W'($urandom_range(1, 10));
            4:       geometry[REG_PAGES_PER_BLK] = 17'd4096;
            default: geometry[REG_PAGES_PER_BLK] = CSR_DATA_W'($urandom_range(1, 4096));
         endcase
         case ($urandom_range(0, 19))
            0:       geometry[REG_BLOCK_COUNT] = '0;
            1:       geometry[REG_BLOCK_COUNT] = CSR_DATA_W'($urandom_range(65537, 131071));
            2:       geometry[REG_BLOCK_COUNT] = 17'd65536;
            3, 4:    geometry[REG_BLOCK_COUNT] = CSR_DATA_W'($urandom_range(1, 16));
            default: geometry[REG_BLOCK_COUNT] = CSR_DATA_W'($urandom_range(1, 65536));
         endcase
         geometry[REG_RAID_MODE] = CSR_DATA_W'($urandom_range(0, 1));
         if ($urandom_range(0, 9) == 0) begin
            geometry[REG_DATA_PAGES] = CSR_DATA_W'($urandom_range(0, 15));
         end else begin
            geometry[REG_DATA_PAGES] = CSR_DATA_W'(2 << $urandom_range(0, 2));
         end
         for (int r = 0; r < 6; r++) begin
            write_register(CSR_INDEX_W'(r), geometry[r]);
         end
         if ($urandom_range(0, 7) == 0) begin
            write_register(REG_UNUSED, CSR_DATA_W'($urandom));
         end
         let_geometry_settle();

         steady = phase >= 4 && phase <= 6;
         probe  = map_page('0);
         total  = probe.map.spb * 64'(cfg_blocks);
         if (phase == HOLD_OFF_PHASE) begin
            hold_request = 1'b1;
         end
         for (int n = 0; n < PAGES_PER_PHASE; n++) begin
            pick = $urandom_range(0, 99);
            if (probe.status != STATUS_OK || pick >= 85) begin
               lp = LP_W'($urandom);
            end else if (pick >= 75) begin
               lp = LP_W'(total - 64'($urandom_range(0, 1)));
            end else begin
               lp = LP_W'($urandom_range(0, 32'(total - 64'd1)));
            end
            send_page(lp, map_page(lp));
            if (!steady && $urandom_range(0, 99) < 14) begin
               req_tvalid = 1'b0;
               @(negedge clock);
            end
         end
      end

      wait_for_results();
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // The response side idles at random, and once holds off long enough for the input to stall.
   initial begin : response_sink
      int stall_left;
      stall_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            stall_left   = HOLD_OFF_CYCLES;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = steady || ($urandom_range(0, 99) >= 14);
         end
      end
   end

   always @(posedge clock) begin : response_check
      mapping_type  want;
      page_map_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = page_map_type'(rsp_tdata);
         if (expected_maps.size() == 0) begin
            $error("response with no request outstanding");
            mismatch_count++;
         end else begin
            want = expected_maps.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_tuser));
            check_field("block", 64'(want.map.blk), 64'(got.blk));
            check_field("stripe", 64'(want.map.stripe), 64'(got.stripe));
            check_field("first page", 64'(want.map.first), 64'(got.first));
            check_field("parity", 64'(want.map.parity), 64'(got.parity));
            check_field("stripe count", 64'(want.map.spb), 64'(got.spb));
            check_field("unused pages", 64'(want.map.tail), 64'(got.tail));
            check_field("page size", 64'(want.map.lpb), 64'(got.lpb));
            check_field("oob size", 64'(want.map.loob), 64'(got.loob));
            check_field("capacity", 64'(want.map.cap), 64'(got.cap));
            check_field("padding", 64'(want.map.pad), 64'(got.pad));
         end
      end
   end

   initial begin : watchdog
      #2000000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
